// File: hw/rtl/bsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg - shared definitions for the barometric compensation block
// Register indexes, pipeline depths and fixed constants of the datapath.
// ----------------------------------------------------------------------------
package bsc_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_TEMP_COEFFS    = 3'd0,
        REG_PRESS_LOW      = 3'd1,
        REG_PRESS_HIGH     = 3'd2,
        REG_PRESS_LAST_HUM = 3'd3,
        REG_HUM_COEFFS     = 3'd4,
        REG_HUM_ENABLED    = 3'd5
    } cfg_reg_t;

    localparam int CFG_DATA_W  = 64;
    localparam int DIV_W       = 64;   // one quotient bit per divider stage
    localparam int PIPE_DEPTH  = 81;   // stages from accept to result
    localparam int TEMP_TAP    = 7;    // first stage of the temperature delay line
    localparam int HUM_TAP     = 16;   // first stage of the humidity delay line
    localparam int TEMP_DELAY  = PIPE_DEPTH - TEMP_TAP + 1;
    localparam int HUM_DELAY   = PIPE_DEPTH - HUM_TAP + 1;

    localparam logic signed [63:0] PRESS_OFFSET = 64'sd128000;
    localparam logic signed [63:0] PRESS_BIAS   = 64'sd140737488355328; // 2^47
    localparam logic signed [63:0] PRESS_SCALE  = 64'sd3125;
    localparam logic        [63:0] PRESS_FULL   = 64'd1048576;
    localparam logic signed [31:0] HUM_OFFSET   = 32'sd76800;
    localparam logic signed [31:0] HUM_MAX      = 32'sd419430400;
    localparam logic signed [31:0] HUM_ROUND    = 32'sd16384;
    localparam logic signed [31:0] HUM_INNER    = 32'sd2097152;
    localparam logic signed [31:0] HUM_HALF     = 32'sd32768;
    localparam logic signed [31:0] HUM_RROUND   = 32'sd8192;

endpackage

// File: hw/rtl/barometric_sensor_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_sensor_compensation - integer sensor compensation pipeline
// Turns one set of raw temperature, pressure and humidity readings into
// compensated values through a fixed-depth pipeline with a staged divider.
// ----------------------------------------------------------------------------
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  input     | start / busy       | raw_temperature, raw_pressure, raw_humidity
//  result    | done (one cycle)   | temperature_centi, pressure_q24_8,
//            |                    | humidity_q22_10
//  config    | wr_en              | wr_index, wr_data
//
//  A beat is taken on every cycle with start high; busy never rises, so the
//  block takes one beat per clock. The depth from each beat to its result
//  is set by the 64-stage restoring divider of the pressure path (one
//  quotient bit per stage) plus the stages around it. The receiver cannot
//  stall: the pipeline advances every cycle and valid bits travel with the
//  data. Reset clears the valid bits and the configuration registers.
//
module barometric_sensor_compensation (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [19:0]         raw_temperature,
    input  logic [19:0]         raw_pressure,
    input  logic [15:0]         raw_humidity,
    output logic                done,
    output logic signed [31:0]  temperature_centi,
    output logic [31:0]         pressure_q24_8,
    output logic [16:0]         humidity_q22_10,
    input  logic                wr_en,
    input  logic [2:0]          wr_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0] wr_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [47:0] press_last_hum_reg;
    logic [31:0] hum_coeffs_reg;
    logic        hum_enabled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg    <= '0;
            press_low_reg      <= '0;
            press_high_reg     <= '0;
            press_last_hum_reg <= '0;
            hum_coeffs_reg     <= '0;
            hum_enabled_reg    <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (bsc_pkg::cfg_reg_t'(wr_index))
                bsc_pkg::REG_TEMP_COEFFS:    temp_coeffs_reg    <= wr_data[47:0];
                bsc_pkg::REG_PRESS_LOW:      press_low_reg      <= wr_data;
                bsc_pkg::REG_PRESS_HIGH:     press_high_reg     <= wr_data;
                bsc_pkg::REG_PRESS_LAST_HUM: press_last_hum_reg <= wr_data[47:0];
                bsc_pkg::REG_HUM_COEFFS:     hum_coeffs_reg     <= wr_data[31:0];
                bsc_pkg::REG_HUM_ENABLED:    hum_enabled_reg    <= wr_data[0];
                default:                     ; // drop writes beyond the list
            endcase
        end
    end

    // Unpack the calibration words, extended to the width of their path
    logic        [15:0] t1;
    logic signed [31:0] t2, t3;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [31:0] h1, h2, h3, h4s, h5, h6;

    assign t1  = temp_coeffs_reg[15:0];
    assign t2  = {{16{temp_coeffs_reg[31]}}, temp_coeffs_reg[31:16]};
    assign t3  = {{16{temp_coeffs_reg[47]}}, temp_coeffs_reg[47:32]};
    assign p1  = {48'd0, press_low_reg[15:0]};
    assign p2  = {{48{press_low_reg[31]}}, press_low_reg[31:16]};
    assign p3  = {{48{press_low_reg[47]}}, press_low_reg[47:32]};
    assign p4  = {{48{press_low_reg[63]}}, press_low_reg[63:48]};
    assign p5  = {{48{press_high_reg[15]}}, press_high_reg[15:0]};
    assign p6  = {{48{press_high_reg[31]}}, press_high_reg[31:16]};
    assign p7  = {{48{press_high_reg[47]}}, press_high_reg[47:32]};
    assign p8  = {{48{press_high_reg[63]}}, press_high_reg[63:48]};
    assign p9  = {{48{press_last_hum_reg[15]}}, press_last_hum_reg[15:0]};
    assign h1  = {24'd0, press_last_hum_reg[23:16]};
    assign h2  = {{16{press_last_hum_reg[39]}}, press_last_hum_reg[39:24]};
    assign h3  = {24'd0, press_last_hum_reg[47:40]};
    assign h4s = {hum_coeffs_reg[11:0], 20'd0};        // H4 pre-shifted by 20
    assign h5  = {20'd0, hum_coeffs_reg[23:12]};
    assign h6  = {{24{hum_coeffs_reg[31]}}, hum_coeffs_reg[31:24]};

    // The block never holds off a beat
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Valid bits, one per stage; advance every cycle
    // ------------------------------------------------------------------
    logic [bsc_pkg::PIPE_DEPTH:1] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[bsc_pkg::PIPE_DEPTH-1:1], start};
        end
    end

    assign done = vld_reg[bsc_pkg::PIPE_DEPTH];

    // ------------------------------------------------------------------
    // Stages 1..15: temperature, fine term, pressure coefficients,
    // humidity front and back end. All 32-bit terms wrap, shifts keep the sign.
    // ------------------------------------------------------------------
    logic signed [31:0] s1_a_reg, s1_d_reg;
    logic signed [31:0] s2_m1_reg, s2_dd_reg;
    logic signed [31:0] s3_v1_reg, s3_m3_reg;
    logic signed [31:0] s4_fine_reg;
    logic signed [31:0] s5_tp_reg, s5_x_reg;
    logic signed [63:0] s5_w1_reg;
    logic signed [31:0] s6_temp_reg, s6_hx5_reg, s6_xh6_reg, s6_xh3_reg;
    logic signed [63:0] s6_ww_reg, s6_w1p5_reg, s6_w1p2_reg;
    logic signed [63:0] s7_w2a_reg, s7_ww3_reg, s7_w1p5_reg, s7_w1p2_reg;
    logic signed [31:0] s7_left_reg, s7_a6_reg, s7_b3_reg;
    logic signed [63:0] s8_w2_reg, s8_w1b_reg;
    logic signed [31:0] s8_im_reg, s8_left_reg;
    logic signed [63:0] s9_w1c_reg, s9_num_reg;
    logic signed [31:0] s9_inner_reg, s9_left_reg;
    logic signed [63:0] s10_w1d_reg, s10_numm_reg;
    logic signed [31:0] s10_rm_reg, s10_left_reg;
    logic signed [63:0] s11_dvs_reg, s11_num_reg;
    logic signed [31:0] s11_right_reg, s11_left_reg;
    logic signed [31:0] s12_hx_reg, s13_hx_reg, s13_s_reg;
    logic signed [31:0] s14_hx_reg, s14_ss_reg, s15_hx_reg, s15_hm_reg;

    // raw pressure and humidity ride along until used
    logic [19:0] p_line_reg [1:8];
    logic [15:0] h_line_reg [1:6];

    always_ff @(posedge clk)
    begin
        p_line_reg[1] <= raw_pressure;
        h_line_reg[1] <= raw_humidity;
        for (int i = 2; i <= 8; i++)
        begin
            p_line_reg[i] <= p_line_reg[i-1];
        end
        for (int i = 2; i <= 6; i++)
        begin
            h_line_reg[i] <= h_line_reg[i-1];
        end

        // stage 1
        s1_a_reg <= $signed({15'd0, raw_temperature[19:3]} - {15'd0, t1, 1'b0});
        s1_d_reg <= $signed({16'd0, raw_temperature[19:4]} - {16'd0, t1});
        // stage 2
        s2_m1_reg <= s1_a_reg * t2;
        s2_dd_reg <= s1_d_reg * s1_d_reg;
        // stage 3
        s3_v1_reg <= s2_m1_reg >>> 11;
        s3_m3_reg <= (s2_dd_reg >>> 12) * t3;
        // stage 4: fine temperature
        s4_fine_reg <= s3_v1_reg + (s3_m3_reg >>> 14);
        // stage 5
        s5_tp_reg <= s4_fine_reg * 32'sd5 + 32'sd128;
        s5_w1_reg <= {{32{s4_fine_reg[31]}}, s4_fine_reg} - bsc_pkg::PRESS_OFFSET;
        s5_x_reg  <= s4_fine_reg - bsc_pkg::HUM_OFFSET;
        // stage 6: the pressure offset term spans 33 bits, square only those
        s6_temp_reg <= s5_tp_reg >>> 8;
        s6_ww_reg   <= $signed(s5_w1_reg[32:0]) * $signed(s5_w1_reg[32:0]);
        s6_w1p5_reg <= s5_w1_reg * p5;
        s6_w1p2_reg <= s5_w1_reg * p2;
        s6_hx5_reg  <= h5 * s5_x_reg;
        s6_xh6_reg  <= s5_x_reg * h6;
        s6_xh3_reg  <= s5_x_reg * h3;
        // stage 7
        s7_w2a_reg  <= s6_ww_reg * p6;
        s7_ww3_reg  <= s6_ww_reg * p3;
        s7_w1p5_reg <= s6_w1p5_reg;
        s7_w1p2_reg <= s6_w1p2_reg;
        s7_left_reg <= $signed($signed({2'd0, h_line_reg[6], 14'd0}) - h4s
                       - s6_hx5_reg + bsc_pkg::HUM_ROUND) >>> 15;
        s7_a6_reg   <= s6_xh6_reg >>> 10;
        s7_b3_reg   <= (s6_xh3_reg >>> 11) + bsc_pkg::HUM_HALF;
        // stage 8
        s8_w2_reg   <= s7_w2a_reg + (s7_w1p5_reg <<< 17) + (p4 <<< 35);
        s8_w1b_reg  <= (s7_ww3_reg >>> 8) + (s7_w1p2_reg <<< 12);
        s8_im_reg   <= s7_a6_reg * s7_b3_reg;
        s8_left_reg <= s7_left_reg;
        // stage 9
        s9_w1c_reg   <= s8_w1b_reg + bsc_pkg::PRESS_BIAS;
        s9_num_reg   <= $signed((bsc_pkg::PRESS_FULL - {44'd0, p_line_reg[8]}) << 31)
                        - s8_w2_reg;
        s9_inner_reg <= s8_im_reg >>> 10;
        s9_left_reg  <= s8_left_reg;
        // stage 10
        s10_w1d_reg  <= s9_w1c_reg * p1;
        s10_numm_reg <= s9_num_reg * bsc_pkg::PRESS_SCALE;
        s10_rm_reg   <= (s9_inner_reg + bsc_pkg::HUM_INNER) * h2 + bsc_pkg::HUM_RROUND;
        s10_left_reg <= s9_left_reg;
        // stage 11: divisor and dividend ready
        s11_dvs_reg   <= s10_w1d_reg >>> 33;
        s11_num_reg   <= s10_numm_reg;
        s11_right_reg <= s10_rm_reg >>> 14;
        s11_left_reg  <= s10_left_reg;
        // stages 12..15: humidity back end
        s12_hx_reg <= s11_left_reg * s11_right_reg;
        s13_hx_reg <= s12_hx_reg;
        s13_s_reg  <= s12_hx_reg >>> 15;
        s14_hx_reg <= s13_hx_reg;
        s14_ss_reg <= s13_s_reg * s13_s_reg;
        s15_hx_reg <= s14_hx_reg;
        s15_hm_reg <= (s14_ss_reg >>> 7) * h1;
    end

    // Humidity finish: subtract, clamp, scale; zero when the channel is absent
    logic signed [31:0] hum_x;
    logic        [16:0] hum_val;

    always_comb
    begin
        hum_x = s15_hx_reg - (s15_hm_reg >>> 4);
        priority if (!hum_enabled_reg || hum_x[31])
        begin
            hum_val = '0;
        end
        else if (hum_x > bsc_pkg::HUM_MAX)
        begin
            hum_val = 17'(bsc_pkg::HUM_MAX >>> 12);
        end
        else
        begin
            hum_val = hum_x[28:12];
        end
    end

    // Delay lines that hold temperature and humidity until pressure is done
    logic signed [31:0] temp_line_reg [0:bsc_pkg::TEMP_DELAY-1];
    logic        [16:0] hum_line_reg  [0:bsc_pkg::HUM_DELAY-1];

    always_ff @(posedge clk)
    begin
        temp_line_reg[0] <= s6_temp_reg;
        for (int i = 1; i < bsc_pkg::TEMP_DELAY; i++)
        begin
            temp_line_reg[i] <= temp_line_reg[i-1];
        end
        hum_line_reg[0] <= hum_val;
        for (int i = 1; i < bsc_pkg::HUM_DELAY; i++)
        begin
            hum_line_reg[i] <= hum_line_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 12 onward: signed division by magnitude, one quotient bit
    // per stage (restoring), sign applied after the last stage.
    // ------------------------------------------------------------------
    localparam int DW = bsc_pkg::DIV_W;

    logic [DW-1:0] dv_n_reg   [0:DW-1];
    logic [DW-1:0] dv_d_reg   [0:DW-1];
    logic [DW-1:0] dv_r_reg   [0:DW-1];
    logic [DW-1:0] dv_q_reg   [0:DW];
    logic          dv_neg_reg [0:DW];
    logic          dv_zero_reg[0:DW];

    logic [DW:0]   dv_rs   [0:DW-1];
    logic          dv_ge   [0:DW-1];

    always_comb
    begin
        for (int j = 0; j < DW; j++)
        begin
            dv_rs[j] = {dv_r_reg[j], dv_n_reg[j][DW-1]};
            dv_ge[j] = (dv_rs[j] >= {1'b0, dv_d_reg[j]});
        end
    end

    always_ff @(posedge clk)
    begin
        dv_n_reg[0]    <= s11_num_reg[63] ? 64'(-s11_num_reg) : s11_num_reg;
        dv_d_reg[0]    <= s11_dvs_reg[63] ? 64'(-s11_dvs_reg) : s11_dvs_reg;
        dv_r_reg[0]    <= '0;
        dv_q_reg[0]    <= '0;
        dv_neg_reg[0]  <= s11_num_reg[63] ^ s11_dvs_reg[63];
        dv_zero_reg[0] <= (s11_dvs_reg == 64'sd0);
        for (int j = 0; j < DW; j++)
        begin
            // the last stage only needs its quotient bit
            if (j < DW - 1)
            begin
                dv_n_reg[j+1] <= {dv_n_reg[j][DW-2:0], 1'b0};
                dv_d_reg[j+1] <= dv_d_reg[j];
                dv_r_reg[j+1] <= dv_ge[j] ? DW'(dv_rs[j] - {1'b0, dv_d_reg[j]})
                                          : dv_rs[j][DW-1:0];
            end
            dv_q_reg[j+1]    <= {dv_q_reg[j][DW-2:0], dv_ge[j]};
            dv_neg_reg[j+1]  <= dv_neg_reg[j];
            dv_zero_reg[j+1] <= dv_zero_reg[j];
        end
    end

    // ------------------------------------------------------------------
    // Stages 77..81: pressure correction terms and final sum
    // ------------------------------------------------------------------
    logic signed [63:0] s77_p_reg, s78_p_reg, s78_q_reg, s78_e2m_reg;
    logic signed [63:0] s79_p_reg, s79_e2m_reg;
    logic        [63:0] s79_ll_reg;
    logic        [31:0] s79_lh_reg;
    logic signed [63:0] s80_p_reg, s80_e1m_reg, s80_e2m_reg;
    logic               s77_zero_reg, s78_zero_reg, s79_zero_reg, s80_zero_reg;
    logic        [31:0] s81_pres_reg;
    logic signed [63:0] pres_sum;

    assign pres_sum = ((s80_p_reg + (s80_e1m_reg >>> 25) + (s80_e2m_reg >>> 19)) >>> 8)
                      + (p7 <<< 4);

    always_ff @(posedge clk)
    begin
        s77_p_reg    <= dv_neg_reg[DW] ? $signed(-dv_q_reg[DW]) : $signed(dv_q_reg[DW]);
        s77_zero_reg <= dv_zero_reg[DW];
        s78_p_reg    <= s77_p_reg;
        s78_q_reg    <= s77_p_reg >>> 13;
        s78_e2m_reg  <= p8 * s77_p_reg;
        s78_zero_reg <= s77_zero_reg;
        // square q from its 32-bit halves; the cross term lands at bit 33
        s79_p_reg    <= s78_p_reg;
        s79_ll_reg   <= {32'd0, s78_q_reg[31:0]} * {32'd0, s78_q_reg[31:0]};
        s79_lh_reg   <= s78_q_reg[31:0] * s78_q_reg[63:32];
        s79_e2m_reg  <= s78_e2m_reg;
        s79_zero_reg <= s78_zero_reg;
        s80_p_reg    <= s79_p_reg;
        s80_e1m_reg  <= p9 * $signed(s79_ll_reg)
                        + ((p9 * $signed({32'd0, s79_lh_reg})) <<< 33);
        s80_e2m_reg  <= s79_e2m_reg;
        s80_zero_reg <= s79_zero_reg;
        s81_pres_reg <= s80_zero_reg ? 32'd0 : pres_sum[31:0];
    end

    assign temperature_centi = temp_line_reg[bsc_pkg::TEMP_DELAY-1];
    assign humidity_q22_10   = hum_line_reg[bsc_pkg::HUM_DELAY-1];
    assign pressure_q24_8    = s81_pres_reg;

endmodule
